/* hdl/kcme_pkg.sv */
// Package for the key change MIDI encoder: field widths, codes and types.
package kcme_pkg;

   localparam int LevelWidth   = 30;
   localparam int PitchWidth   = 7;
   localparam int ChannelWidth = 4;
   localparam int VelWidth     = 7;
   localparam int CodeWidth    = 4;
   localparam int StatusWidth  = 8;
   localparam int CsrIdxWidth  = 2;
   localparam int CsrDataWidth = 7;

   localparam logic [CodeWidth-1:0]  EvNoteOn  = 4'd9;
   localparam logic [CodeWidth-1:0]  EvNoteOff = 4'd8;
   localparam logic [PitchWidth-1:0] PitchMax  = 7'd127;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_BASE_PITCH   = 2'd0,
      CSR_MIDI_CHANNEL = 2'd1,
      CSR_ON_VELOCITY  = 2'd2
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

/* hdl/key_change_midi_encoder.sv */
// Top level of the key change MIDI encoder: scan compare, bit walker and output register.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-----------------------------------------------
//   req     | in  | req_valid/req_ready  | req_key_levels (active-low key pins)
//   rsp     | out | rsp_valid/rsp_ready  | cable_code, status_byte, note_pitch, velocity, last
//   csr     | in  | csr_wr_en            | csr_index, csr_wdata (write only, no wait)
//
// A scan beat is accepted in the idle state; the one-bit-a-cycle shift walker then steps
// through each key position up to the highest changed key (at most min(KEY_COUNT,30)
// positions). A stalled rsp beat holds the walker on a changed key; unchanged keys
// still advance. req_ready is high only while the walker is idle. Reset is synchronous;
// it clears the stored pressed set, the registers to their defaults and rsp_valid.
module key_change_midi_encoder #(
   parameter int KEY_COUNT = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [kcme_pkg::LevelWidth-1:0]     req_key_levels,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [kcme_pkg::CodeWidth-1:0]      rsp_cable_code,
   output logic [kcme_pkg::StatusWidth-1:0]    rsp_status_byte,
   output logic [kcme_pkg::PitchWidth-1:0]     rsp_note_pitch,
   output logic [kcme_pkg::VelWidth-1:0]       rsp_note_velocity,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic [kcme_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [kcme_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import kcme_pkg::*;

   // keys that exist: below both KEY_COUNT and the pin word width
   localparam int KeyBits = (KEY_COUNT < LevelWidth) ? KEY_COUNT : LevelWidth;
   localparam int IdxW    = (KeyBits > 1) ? $clog2(KeyBits) : 1;

   // configuration registers
   logic [PitchWidth-1:0]   base_pitch_ff;
   logic [ChannelWidth-1:0] channel_ff;
   logic [VelWidth-1:0]     on_vel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_pitch_ff <= 7'd36;
         channel_ff    <= '0;
         on_vel_ff     <= 7'd127;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_BASE_PITCH:   base_pitch_ff <= csr_wdata[PitchWidth-1:0];
            CSR_MIDI_CHANNEL: channel_ff    <= csr_wdata[ChannelWidth-1:0];
            CSR_ON_VELOCITY:  on_vel_ff     <= csr_wdata[VelWidth-1:0];
            default: ;  // unknown index: write dropped
         endcase
      end
   end

   // scan state and walker registers
   state_type            state_ff, state_in;
   logic [KeyBits-1:0]   pressed_ff;
   logic [KeyBits-1:0]   chg_ff, chg_in;    // changed keys, shifted down as we walk
   logic [KeyBits-1:0]   now_ff, now_in;    // new pressed set, shifted alongside
   logic [IdxW-1:0]      idx_ff, idx_in;
   logic                 rsp_valid_ff;

   logic [KeyBits-1:0]   now_scan;
   logic                 req_fire;
   logic                 out_free;
   logic                 cur_chg;
   logic                 rest_zero;
   logic                 emit;
   logic                 advance;

   assign now_scan  = ~req_key_levels[KeyBits-1:0];
   assign req_fire  = req_valid && req_ready;
   assign cur_chg   = chg_ff[0];
   assign rest_zero = ((chg_ff >> 1) == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (advance && rest_zero) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      emit      = 1'b0;
      advance   = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_WALK: begin
            emit    = cur_chg && out_free;
            advance = !cur_chg || out_free;  // stall only on a changed key
         end
         default: ;
      endcase
   end

   // walker datapath: one-bit shift per step
   always_comb begin
      chg_in = chg_ff;
      now_in = now_ff;
      idx_in = idx_ff;
      if (req_fire) begin
         chg_in = now_scan ^ pressed_ff;
         now_in = now_scan;
         idx_in = '0;
      end else if (advance) begin
         chg_in = chg_ff >> 1;
         now_in = now_ff >> 1;
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pressed_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (req_fire) pressed_ff <= now_scan;
      end
   end

   always_ff @(posedge clock) begin
      chg_ff <= chg_in;
      now_ff <= now_in;
      idx_ff <= idx_in;
   end

   // packet fields for the current key
   logic [PitchWidth:0]     pitch_sum;
   logic [PitchWidth-1:0]   pitch_sat;
   logic [CodeWidth-1:0]    code_sel;

   assign pitch_sum = {1'b0, base_pitch_ff} + (PitchWidth+1)'(idx_ff);
   assign pitch_sat = pitch_sum[PitchWidth] ? PitchMax : pitch_sum[PitchWidth-1:0];
   assign code_sel  = now_ff[0] ? EvNoteOn : EvNoteOff;

   // output register
   logic [CodeWidth-1:0]    code_ff;
   logic [StatusWidth-1:0]  status_ff;
   logic [PitchWidth-1:0]   pitch_ff;
   logic [VelWidth-1:0]     vel_ff;
   logic                    last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         code_ff   <= code_sel;
         status_ff <= {code_sel, channel_ff};
         pitch_ff  <= pitch_sat;
         vel_ff    <= now_ff[0] ? on_vel_ff : '0;
         last_ff   <= rest_zero;  // no changed key above this one: flush
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cable_code    = code_ff;
   assign rsp_status_byte   = status_ff;
   assign rsp_note_pitch    = pitch_ff;
   assign rsp_note_velocity = vel_ff;
   assign rsp_last          = last_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts_walk: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_WALK)
      else $error("accepted scan did not start the walk");

   a_emit_on_change: assert property (@(posedge clock) disable iff (reset)
      emit |-> state_ff == ST_WALK && chg_ff[0])
      else $error("packet emitted for an unchanged key");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !emit)
      else $error("held packet overwritten");

   a_status_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_status_byte[StatusWidth-1:ChannelWidth] == rsp_cable_code)
      else $error("status byte high nibble differs from cable code");

   a_note_off_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_cable_code == EvNoteOff |-> rsp_note_velocity == '0)
      else $error("note off with non-zero velocity");
`endif

endmodule
